@@ rtl/otp_pkg.sv @@
package otp_pkg;

    // Token geometry
    localparam int TOKEN_WORDS = 2;
    localparam int CNT_W       = $clog2(TOKEN_WORDS + 1);
    localparam int IDX_W       = (TOKEN_WORDS > 1) ? $clog2(TOKEN_WORDS) : 1;

    // Durations
    localparam logic [31:0] DUR_DEFAULT = 32'd120000;
    localparam logic [31:0] DUR_MAX     = 32'h7fff_ffff;

    // Stream widths
    localparam int IN_W  = 168;
    localparam int OUT_W = 104;

    // Command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // Configuration register indexes
    localparam logic CFG_TOKEN_LIFETIME = 1'b0;
    localparam logic CFG_WINDOW_LENGTH  = 1'b1;

    // Raw command codes on the stream
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_OPEN   = 3'd1;
    localparam logic [2:0] CMD_BIND   = 3'd2;
    localparam logic [2:0] CMD_PROOF  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_CANCEL = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREPARED = 3'd1,
        PH_WINDOW   = 3'd2,
        PH_CONSUMED = 3'd3,
        PH_EXPIRED  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STATE    = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_ARG      = 3'd3,
        ST_SESSION  = 3'd4,
        ST_CONSUMED = 3'd5,
        ST_GEN      = 3'd6,
        ST_TOKEN    = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        K_LOAD,
        K_OPEN,
        K_BIND,
        K_PROOF,
        K_READ,
        K_CANCEL,
        K_ILLEGAL
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EXEC,
        BK_MAT
    } back_state_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        sess_zero;
        logic [31:0] now_ms;
        logic [31:0] session_number;
        logic [31:0] claimed_generation;
        logic [63:0] token_chunk;
        logic        final_word;
    } item_t;

    // Zero selects the default, anything above 2^31-1 clamps
    function automatic logic [31:0] clean_duration(input logic [31:0] v);
        logic [31:0] r;
        if (v == 32'd0)
            r = DUR_DEFAULT;
        else if (v[31])
            r = DUR_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ rtl/otp_front.sv @@
module otp_front
    import otp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            s_tlast,
    output logic            push,
    output item_t           push_item,
    input  logic            q_full
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    item_t     stage_item_reg;
    item_t     stage_item_next;
    cmd_kind_t kind;
    logic      take;

    // Classify the raw command code
    always_comb
    begin
        case (s_tdata[2:0])
            CMD_LOAD:   kind = K_LOAD;
            CMD_OPEN:   kind = K_OPEN;
            CMD_BIND:   kind = K_BIND;
            CMD_PROOF:  kind = K_PROOF;
            CMD_READ:   kind = K_READ;
            CMD_CANCEL: kind = K_CANCEL;
            default:    kind = K_ILLEGAL;
        endcase
    end

    // Accept a beat whenever the stage is empty or drains this cycle
    assign push     = stage_valid_reg && !q_full;
    assign s_tready = !stage_valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (push)
            stage_valid_next = 1'b0;
        if (take)
        begin
            stage_valid_next                   = 1'b1;
            stage_item_next.kind               = kind;
            stage_item_next.now_ms             = s_tdata[34:3];
            stage_item_next.session_number     = s_tdata[66:35];
            stage_item_next.sess_zero          = (s_tdata[66:35] == 32'd0);
            stage_item_next.claimed_generation = s_tdata[98:67];
            stage_item_next.token_chunk        = s_tdata[162:99];
            stage_item_next.final_word         = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
    end

    assign push_item = stage_item_reg;

endmodule

@@ rtl/otp_queue.sv @@
module otp_queue
    import otp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t             entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/otp_back.sv @@
module otp_back
    import otp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             q_empty,
    input  item_t            q_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    // Configuration, held already cleaned
    logic [31:0] lifetime_reg;
    logic [31:0] window_len_reg;

    // Sequencer
    back_state_t      state_reg, state_next;
    item_t            cur_reg, cur_next;
    logic [IDX_W-1:0] mat_idx_reg, mat_idx_next;

    // Pairing state
    phase_t      phase_reg, phase_next;
    logic [63:0] live_reg [TOKEN_WORDS];
    logic [63:0] live_next [TOKEN_WORDS];
    logic [63:0] staged_reg [TOKEN_WORDS];
    logic [63:0] staged_next [TOKEN_WORDS];
    logic [CNT_W-1:0] ld_cnt_reg, ld_cnt_next;
    logic             ld_over_reg, ld_over_next;
    logic [CNT_W-1:0] pf_cnt_reg, pf_cnt_next;
    logic             pf_over_reg, pf_over_next;
    logic             pf_diff_reg, pf_diff_next;
    logic [31:0]      gen_reg, gen_next;
    logic [31:0]      bound_reg, bound_next;
    logic [31:0]      tok_dl_reg, tok_dl_next;
    logic [31:0]      win_dl_reg, win_dl_next;

    // Timing checks computed in the check state and registered ahead of execution
    logic        tok_hit_reg, tok_hit_next;
    logic        win_hit_reg, win_hit_next;
    logic [31:0] new_tok_dl_reg, new_tok_dl_next;
    logic [31:0] new_win_dl_reg, new_win_dl_next;
    logic [31:0] tok_diff;
    logic [31:0] win_diff;

    // Output register
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    phase_t      out_phase_reg, out_phase_next;
    logic [31:0] out_gen_reg, out_gen_next;
    logic [63:0] out_word_reg, out_word_next;
    logic        out_active_reg, out_active_next;
    logic        out_last_reg, out_last_next;

    // Execution helpers
    logic        out_free;
    logic        lapsed;
    logic        ld_fits;
    logic        pf_fits;
    logic [CNT_W-1:0] ld_cnt_inc;
    logic [CNT_W-1:0] pf_cnt_inc;
    logic        ld_over_inc;
    logic        pf_over_inc;
    logic        pf_diff_inc;
    logic [63:0] staged_eff [TOKEN_WORDS];
    logic [31:0] gen_bump;
    status_t     status;

    assign out_free = !out_valid_reg || m_tready;
    assign tok_diff = cur_reg.now_ms - tok_dl_reg;
    assign win_diff = cur_reg.now_ms - win_dl_reg;
    assign lapsed   = tok_hit_reg || ((phase_reg == PH_WINDOW) && win_hit_reg);
    assign ld_fits  = (ld_cnt_reg < CNT_W'(TOKEN_WORDS));
    assign pf_fits  = (pf_cnt_reg < CNT_W'(TOKEN_WORDS));
    assign ld_cnt_inc  = ld_fits ? ld_cnt_reg + 1'b1 : ld_cnt_reg;
    assign pf_cnt_inc  = pf_fits ? pf_cnt_reg + 1'b1 : pf_cnt_reg;
    assign ld_over_inc = ld_over_reg || !ld_fits;
    assign pf_over_inc = pf_over_reg || !pf_fits;
    assign pf_diff_inc = pf_diff_reg ||
                         (pf_fits && (cur_reg.token_chunk != live_reg[pf_cnt_reg[IDX_W-1:0]]));
    assign gen_bump = (gen_reg == 32'hffff_ffff) ? 32'd1 : gen_reg + 32'd1;

    // Staged token with this beat's word slotted in
    always_comb
    begin
        for (int i = 0; i < TOKEN_WORDS; i++)
            staged_eff[i] = staged_reg[i];
        if (ld_fits)
            staged_eff[ld_cnt_reg[IDX_W-1:0]] = cur_reg.token_chunk;
    end

    // Sequencer: pop, check deadlines, execute, stream material words
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        mat_idx_next    = mat_idx_reg;
        phase_next      = phase_reg;
        ld_cnt_next     = ld_cnt_reg;
        ld_over_next    = ld_over_reg;
        pf_cnt_next     = pf_cnt_reg;
        pf_over_next    = pf_over_reg;
        pf_diff_next    = pf_diff_reg;
        gen_next        = gen_reg;
        bound_next      = bound_reg;
        tok_dl_next     = tok_dl_reg;
        win_dl_next     = win_dl_reg;
        tok_hit_next    = tok_hit_reg;
        win_hit_next    = win_hit_reg;
        new_tok_dl_next = new_tok_dl_reg;
        new_win_dl_next = new_win_dl_reg;
        for (int i = 0; i < TOKEN_WORDS; i++)
        begin
            live_next[i]   = live_reg[i];
            staged_next[i] = staged_reg[i];
        end
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_phase_next  = out_phase_reg;
        out_gen_next    = out_gen_reg;
        out_word_next   = out_word_reg;
        out_active_next = out_active_reg;
        out_last_next   = out_last_reg;
        status          = ST_OK;
        pop             = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cur_next   = q_item;
                    state_next = BK_CHECK;
                end
            end

            BK_CHECK:
            begin
                tok_hit_next    = !tok_diff[31];
                win_hit_next    = !win_diff[31];
                new_tok_dl_next = cur_reg.now_ms + lifetime_reg;
                new_win_dl_next = cur_reg.now_ms + window_len_reg;
                state_next      = BK_EXEC;
            end

            BK_EXEC:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                    case (cur_reg.kind)
                        K_LOAD:
                        begin
                            if (ld_fits)
                                staged_next[ld_cnt_reg[IDX_W-1:0]] = cur_reg.token_chunk;
                            ld_cnt_next  = ld_cnt_inc;
                            ld_over_next = ld_over_inc;
                            if (cur_reg.final_word)
                            begin
                                ld_cnt_next  = '0;
                                ld_over_next = 1'b0;
                                if (ld_over_inc || ld_cnt_inc != CNT_W'(TOKEN_WORDS))
                                    status = ST_STATE;
                                else
                                begin
                                    for (int i = 0; i < TOKEN_WORDS; i++)
                                        live_next[i] = staged_eff[i];
                                    gen_next    = gen_bump;
                                    bound_next  = 32'd0;
                                    tok_dl_next = new_tok_dl_reg;
                                    win_dl_next = 32'd0;
                                    phase_next  = PH_PREPARED;
                                end
                            end
                        end

                        K_OPEN:
                        begin
                            if (phase_reg != PH_PREPARED && phase_reg != PH_WINDOW)
                                status = ST_STATE;
                            else if (lapsed)
                            begin
                                phase_next = PH_EXPIRED;
                                status     = ST_EXPIRED;
                            end
                            else if (phase_reg == PH_PREPARED)
                            begin
                                win_dl_next = new_win_dl_reg;
                                phase_next  = PH_WINDOW;
                            end
                        end

                        K_BIND:
                        begin
                            if (cur_reg.sess_zero)
                                status = ST_ARG;
                            else if (phase_reg != PH_WINDOW)
                                status = ST_STATE;
                            else if (lapsed)
                            begin
                                phase_next = PH_EXPIRED;
                                status     = ST_EXPIRED;
                            end
                            else if (bound_reg != 32'd0 && bound_reg != cur_reg.session_number)
                                status = ST_SESSION;
                            else
                                bound_next = cur_reg.session_number;
                        end

                        K_PROOF:
                        begin
                            pf_cnt_next  = pf_cnt_inc;
                            pf_over_next = pf_over_inc;
                            pf_diff_next = pf_diff_inc;
                            if (cur_reg.final_word)
                            begin
                                pf_cnt_next  = '0;
                                pf_over_next = 1'b0;
                                pf_diff_next = 1'b0;
                                if (cur_reg.sess_zero)
                                    status = ST_ARG;
                                else if (pf_over_inc || pf_cnt_inc != CNT_W'(TOKEN_WORDS))
                                    status = ST_ARG;
                                else if (phase_reg == PH_CONSUMED)
                                    status = ST_CONSUMED;
                                else if (phase_reg == PH_IDLE)
                                    status = ST_STATE;
                                else if (phase_reg == PH_EXPIRED)
                                    status = ST_EXPIRED;
                                else if (phase_reg != PH_WINDOW)
                                    status = ST_STATE;
                                else if (lapsed)
                                begin
                                    phase_next = PH_EXPIRED;
                                    status     = ST_EXPIRED;
                                end
                                else if (cur_reg.claimed_generation != gen_reg)
                                    status = ST_GEN;
                                else if (pf_diff_inc)
                                    status = ST_TOKEN;
                                else if (bound_reg != 32'd0 &&
                                         bound_reg != cur_reg.session_number)
                                    status = ST_SESSION;
                                else
                                begin
                                    bound_next = cur_reg.session_number;
                                    for (int i = 0; i < TOKEN_WORDS; i++)
                                        live_next[i] = 64'd0;
                                    phase_next = PH_CONSUMED;
                                end
                            end
                        end

                        K_READ:
                        begin
                            if (phase_reg != PH_PREPARED && phase_reg != PH_WINDOW)
                                status = ST_STATE;
                            else if (lapsed)
                                status = ST_EXPIRED;
                        end

                        K_CANCEL:
                        begin
                            for (int i = 0; i < TOKEN_WORDS; i++)
                                live_next[i] = 64'd0;
                            gen_next     = 32'd0;
                            bound_next   = 32'd0;
                            tok_dl_next  = 32'd0;
                            win_dl_next  = 32'd0;
                            ld_cnt_next  = '0;
                            ld_over_next = 1'b0;
                            pf_cnt_next  = '0;
                            pf_over_next = 1'b0;
                            pf_diff_next = 1'b0;
                            phase_next   = PH_IDLE;
                        end

                        default:
                        begin
                            status = ST_STATE;
                        end
                    endcase

                    // Load the result beat
                    out_valid_next  = 1'b1;
                    out_status_next = status;
                    out_phase_next  = phase_next;
                    out_gen_next    = 32'd0;
                    out_word_next   = 64'd0;
                    out_active_next = 1'b0;
                    out_last_next   = 1'b1;
                    if (cur_reg.kind == K_READ && status == ST_OK)
                    begin
                        out_gen_next    = gen_reg;
                        out_word_next   = live_reg[0];
                        out_active_next = 1'b1;
                        out_last_next   = (TOKEN_WORDS == 1);
                        if (TOKEN_WORDS > 1)
                        begin
                            mat_idx_next = IDX_W'(1);
                            state_next   = BK_MAT;
                        end
                    end
                end
            end

            BK_MAT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_phase_next  = phase_reg;
                    out_gen_next    = gen_reg;
                    out_word_next   = live_reg[mat_idx_reg];
                    out_active_next = 1'b1;
                    out_last_next   = (mat_idx_reg == IDX_W'(TOKEN_WORDS - 1));
                    mat_idx_next    = mat_idx_reg + 1'b1;
                    if (mat_idx_reg == IDX_W'(TOKEN_WORDS - 1))
                        state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            phase_reg      <= PH_IDLE;
            ld_cnt_reg     <= '0;
            ld_over_reg    <= 1'b0;
            pf_cnt_reg     <= '0;
            pf_over_reg    <= 1'b0;
            pf_diff_reg    <= 1'b0;
            gen_reg        <= 32'd0;
            bound_reg      <= 32'd0;
            tok_dl_reg     <= 32'd0;
            win_dl_reg     <= 32'd0;
            out_valid_reg  <= 1'b0;
            lifetime_reg   <= DUR_DEFAULT;
            window_len_reg <= DUR_DEFAULT;
            for (int i = 0; i < TOKEN_WORDS; i++)
                live_reg[i] <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ld_cnt_reg    <= ld_cnt_next;
            ld_over_reg   <= ld_over_next;
            pf_cnt_reg    <= pf_cnt_next;
            pf_over_reg   <= pf_over_next;
            pf_diff_reg   <= pf_diff_next;
            gen_reg       <= gen_next;
            bound_reg     <= bound_next;
            tok_dl_reg    <= tok_dl_next;
            win_dl_reg    <= win_dl_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < TOKEN_WORDS; i++)
                live_reg[i] <= live_next[i];
            // Clean durations as they are written
            if (cfg_we && cfg_index == CFG_TOKEN_LIFETIME)
                lifetime_reg <= clean_duration(cfg_data);
            if (cfg_we && cfg_index == CFG_WINDOW_LENGTH)
                window_len_reg <= clean_duration(cfg_data);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        mat_idx_reg    <= mat_idx_next;
        tok_hit_reg    <= tok_hit_next;
        win_hit_reg    <= win_hit_next;
        new_tok_dl_reg <= new_tok_dl_next;
        new_win_dl_reg <= new_win_dl_next;
        out_status_reg <= out_status_next;
        out_phase_reg  <= out_phase_next;
        out_gen_reg    <= out_gen_next;
        out_word_reg   <= out_word_next;
        out_active_reg <= out_active_next;
        out_last_reg   <= out_last_next;
        for (int i = 0; i < TOKEN_WORDS; i++)
            staged_reg[i] <= staged_next[i];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_active_reg, out_word_reg, out_gen_reg,
                       out_phase_reg, out_status_reg};

endmodule

@@ rtl/one_time_token_pairing_fsm.sv @@
// One-time pairing controller. Commands enter on the s_ stream, one beat each,
// and every command answers with one result beat on the m_ stream; a successful
// material read answers with TOKEN_WORDS beats, word 0 first, with tlast on the
// final one. An input register classifies each beat and hands it through a
// two-entry command queue to the execution sequencer, which takes a command
// through dequeue, deadline check and execute in turn and streams any further
// material words before it dequeues the next one. The output register lets
// the input keep accepting while a result waits. Lifetime and window length
// must be written on the cfg port only while no command is in flight; the
// block itself does not enforce this. Zero selects 120000 ms and values above
// 2^31-1 clamp. Deadlines count as reached when bit 31 of (now_ms - deadline)
// is clear, so the millisecond clock may wrap freely.
module one_time_token_pairing_fsm
    import otp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration writes
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    // Command beats
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[2:0], now_ms[34:3], session_number[66:35],
    // claimed_generation[98:67], token_chunk[162:99], zero pad[167:163]
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,   // final_word
    // Result beats
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], phase_now[5:3], generation_out[37:6],
    // material_word[101:38], material_active[102], zero pad[103]
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast    // last_result
);

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  pop;
    item_t pop_item;
    logic  q_empty;

    otp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    otp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    otp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/sv/one_time_token_pairing_fsm_test.sv @@
module one_time_token_pairing_fsm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import otp_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SHOWN_MISMATCHES = 10;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] now;
        logic [31:0] sess;
        logic [31:0] gen;
        logic [63:0] word;
        logic        fin;
    } command_beat_t;

    typedef struct {
        status_t     status;
        phase_t      phase;
        logic [31:0] gen;
        logic [63:0] word;
        logic        active;
        logic        last;
    } reply_t;

    // Tracks the pairing state and the replies still owed by the block
    class pairing_tracker;
        logic [31:0] lifetime_cfg;
        logic [31:0] window_cfg;
        phase_t      phase;
        logic [63:0] live_word[TOKEN_WORDS];
        logic [63:0] staged_word[TOKEN_WORDS];
        int unsigned load_n;
        int unsigned proof_n;
        bit          load_over;
        bit          proof_over;
        bit          proof_differs;
        logic [31:0] generation;
        logic [31:0] bound;
        logic [31:0] token_dl;
        logic [31:0] window_dl;
        reply_t      awaited[$];
        int unsigned failures;
        int unsigned checked;

        function new();
            lifetime_cfg = 32'd120000;
            window_cfg = 32'd120000;
            foreach (staged_word[k])
                staged_word[k] = '0;
            failures = 0;
            checked = 0;
            clear_all();
        endfunction

        // Drop token, generation, session, deadlines and partial sequences
        function void clear_all();
            foreach (live_word[k])
                live_word[k] = '0;
            generation = '0;
            bound = '0;
            token_dl = '0;
            window_dl = '0;
            load_n = 0;
            load_over = 0;
            proof_n = 0;
            proof_over = 0;
            proof_differs = 0;
            phase = PH_IDLE;
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == CFG_TOKEN_LIFETIME)
                lifetime_cfg = value;
            else
                window_cfg = value;
        endfunction

        // Zero selects 120000 ms, values above 2^31-1 saturate
        function logic [31:0] bounded_ms(input logic [31:0] v);
            if (v == 32'd0)
                return 32'd120000;
            if (v > 32'h7fff_ffff)
                return 32'h7fff_ffff;
            return v;
        endfunction

        function bit due(input logic [31:0] now, input logic [31:0] dl);
            logic [31:0] diff;
            diff = now - dl;
            return !diff[31];
        endfunction

        function bit lapsed(input logic [31:0] now);
            if (phase == PH_WINDOW)
                return due(now, token_dl) || due(now, window_dl);
            return due(now, token_dl);
        endfunction

        function void expect_single(input status_t st);
            reply_t r;
            r.status = st;
            r.phase = phase;
            r.gen = '0;
            r.word = '0;
            r.active = 1'b0;
            r.last = 1'b1;
            awaited.push_back(r);
        endfunction

        function status_t load_word(input logic [31:0] now, input logic [63:0] word,
                                    input bit fin);
            if (load_n < TOKEN_WORDS) begin
                staged_word[load_n] = word;
                load_n++;
            end
            else
                load_over = 1;
            if (!fin)
                return ST_OK;
            if (load_over || load_n != TOKEN_WORDS) begin
                load_n = 0;
                load_over = 0;
                return ST_STATE;
            end
            load_n = 0;
            load_over = 0;
            live_word = staged_word;
            generation++;
            if (generation == 32'd0)
                generation++;
            bound = '0;
            token_dl = now + bounded_ms(lifetime_cfg);
            window_dl = '0;
            phase = PH_PREPARED;
            return ST_OK;
        endfunction

        function status_t open_window(input logic [31:0] now);
            if (phase != PH_PREPARED && phase != PH_WINDOW)
                return ST_STATE;
            if ((phase == PH_WINDOW && due(now, window_dl)) || lapsed(now)) begin
                phase = PH_EXPIRED;
                return ST_EXPIRED;
            end
            if (phase == PH_PREPARED) begin
                window_dl = now + bounded_ms(window_cfg);
                phase = PH_WINDOW;
            end
            return ST_OK;
        endfunction

        function status_t attach_session(input logic [31:0] now, input logic [31:0] sess);
            if (sess == 32'd0)
                return ST_ARG;
            if (phase != PH_WINDOW)
                return ST_STATE;
            if (lapsed(now)) begin
                phase = PH_EXPIRED;
                return ST_EXPIRED;
            end
            if (bound != 32'd0 && bound != sess)
                return ST_SESSION;
            bound = sess;
            return ST_OK;
        endfunction

        function status_t proof_word(input logic [31:0] now, input logic [31:0] sess,
                                     input logic [31:0] gen, input logic [63:0] word,
                                     input bit fin);
            bit bad_count;
            bit differs;
            if (proof_n < TOKEN_WORDS) begin
                if (word != live_word[proof_n])
                    proof_differs = 1;
                proof_n++;
            end
            else
                proof_over = 1;
            if (!fin)
                return ST_OK;
            bad_count = proof_over || proof_n != TOKEN_WORDS;
            differs = proof_differs;
            proof_n = 0;
            proof_over = 0;
            proof_differs = 0;
            // Checks run in a fixed order; the first hit decides the status
            if (sess == 32'd0 || bad_count)
                return ST_ARG;
            if (phase == PH_CONSUMED)
                return ST_CONSUMED;
            if (phase == PH_IDLE)
                return ST_STATE;
            if (phase == PH_EXPIRED)
                return ST_EXPIRED;
            if (phase != PH_WINDOW)
                return ST_STATE;
            if (lapsed(now)) begin
                phase = PH_EXPIRED;
                return ST_EXPIRED;
            end
            if (gen != generation)
                return ST_GEN;
            if (differs)
                return ST_TOKEN;
            if (bound != 32'd0 && bound != sess)
                return ST_SESSION;
            bound = sess;
            foreach (live_word[k])
                live_word[k] = '0;
            phase = PH_CONSUMED;
            return ST_OK;
        endfunction

        // Advance the state by one accepted command and queue its replies
        function void note_command(input command_beat_t b);
            reply_t r;
            case (b.cmd)
                CMD_LOAD:   expect_single(load_word(b.now, b.word, b.fin));
                CMD_OPEN:   expect_single(open_window(b.now));
                CMD_BIND:   expect_single(attach_session(b.now, b.sess));
                CMD_PROOF:  expect_single(proof_word(b.now, b.sess, b.gen, b.word, b.fin));
                CMD_READ: begin
                    if (phase != PH_PREPARED && phase != PH_WINDOW)
                        expect_single(ST_STATE);
                    else if (lapsed(b.now))
                        expect_single(ST_EXPIRED);
                    else begin
                        for (int k = 0; k < TOKEN_WORDS; k++) begin
                            r.status = ST_OK;
                            r.phase = phase;
                            r.gen = generation;
                            r.word = live_word[k];
                            r.active = 1'b1;
                            r.last = (k == TOKEN_WORDS - 1);
                            awaited.push_back(r);
                        end
                    end
                end
                CMD_CANCEL: begin
                    clear_all();
                    expect_single(ST_OK);
                end
                default:    expect_single(ST_STATE);
            endcase
        endfunction

        // Compare one result beat against the oldest outstanding reply
        function void check_reply(input reply_t got);
            reply_t want;
            checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= SHOWN_MISMATCHES)
                    $display("unexpected result beat: status %0d phase %0d word %h",
                             got.status, got.phase, got.word);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.phase !== want.phase
                    || got.gen !== want.gen || got.word !== want.word
                    || got.active !== want.active || got.last !== want.last) begin
                failures++;
                if (failures <= SHOWN_MISMATCHES) begin
                    $display("mismatch exp: status %0d phase %0d gen %h word %h act %b last %b",
                             want.status, want.phase, want.gen, want.word,
                             want.active, want.last);
                    $display("         got: status %0d phase %0d gen %h word %h act %b last %b",
                             got.status, got.phase, got.gen, got.word,
                             got.active, got.last);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [31:0]        cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;

    pairing_tracker     tracker;
    bit                 quiet = 1'b0;
    int unsigned        stall_cycles = 0;
    int unsigned        sent_total = 0;
    int unsigned        sent_by_cmd[8];
    int unsigned        settings_used = 0;
    int unsigned        step_ms = 1000;
    logic [31:0]        clock_ms = '0;

    one_time_token_pairing_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // Stall the result side now and then
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 8);

    // Check result beats and guard against a hang; values are stable at negedge
    always @(negedge clk)
    begin
        reply_t got;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[2:0]);
                got.phase = phase_t'(m_tdata[5:3]);
                got.gen = m_tdata[37:6];
                got.word = m_tdata[101:38];
                got.active = m_tdata[102];
                got.last = m_tlast;
                tracker.check_reply(got);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d replies outstanding",
                         STALL_LIMIT, tracker.awaited.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Advance the millisecond clock, with a rare jump anywhere
    task automatic tick();
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_ms);
    endtask

    // Drive one command beat and hold it until accepted
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] now,
                                input logic [31:0] sess, input logic [31:0] gen,
                                input logic [63:0] word, input bit fin);
        command_beat_t b;
        bit go;
        b.cmd = cmd;
        b.now = now;
        b.sess = sess;
        b.gen = gen;
        b.word = word;
        b.fin = fin;
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, word, gen, sess, now, cmd};
        s_tlast <= fin;
        go = 0;
        while (!go) begin
            @(negedge clk);
            go = s_tready;
            @(posedge clk);
        end
        tracker.note_command(b);
        sent_by_cmd[cmd]++;
        sent_total++;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 15) begin
            tick();
            send_command(3'($urandom_range(0, 7)),
                         $urandom_range(0, 1) ? clock_ms : $urandom,
                         $urandom, $urandom, rand64(), 1'($urandom_range(0, 1)));
        end
    endtask

    // One pairing attempt: load, open, bind, read, prove, with random faults
    task automatic pairing_attempt();
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] pw[TOKEN_WORDS];
        logic [31:0] sess;
        logic [31:0] psess;
        logic [31:0] pgen;
        int nwords;
        int k;
        int pick;
        w0 = rand64();
        w1 = rand64();
        // Occasionally a load of the wrong length first
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            tick();
            send_command(CMD_LOAD, clock_ms, $urandom, $urandom, rand64(), 1'b1);
        end
        else if (pick == 1) begin
            for (k = 0; k <= TOKEN_WORDS; k++) begin
                tick();
                send_command(CMD_LOAD, clock_ms, $urandom, $urandom, rand64(),
                             k == TOKEN_WORDS);
            end
        end
        tick();
        send_command(CMD_LOAD, clock_ms, $urandom, $urandom, w0, 1'b0);
        tick();
        send_command(CMD_LOAD, clock_ms, $urandom, $urandom, w1, 1'b1);
        maybe_noise();
        if ($urandom_range(0, 9) != 0) begin
            tick();
            send_command(CMD_OPEN, clock_ms, $urandom, $urandom, rand64(),
                         1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) == 0) begin
            tick();
            send_command(CMD_OPEN, clock_ms, $urandom, $urandom, rand64(),
                         1'($urandom_range(0, 1)));
        end
        sess = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
        if ($urandom_range(0, 9) < 8) begin
            tick();
            send_command(CMD_BIND, clock_ms, sess, $urandom, rand64(),
                         1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) == 0) begin
            tick();
            send_command(CMD_BIND, clock_ms, $urandom, $urandom, rand64(), 1'b0);
        end
        if ($urandom_range(0, 1)) begin
            tick();
            send_command(CMD_READ, clock_ms, $urandom, $urandom, rand64(),
                         1'($urandom_range(0, 1)));
        end
        maybe_noise();
        // Build the proof from the live token, sometimes damaged
        for (k = 0; k < TOKEN_WORDS; k++)
            pw[k] = tracker.live_word[k];
        if ($urandom_range(0, 6) == 0) begin
            k = $urandom_range(0, TOKEN_WORDS - 1);
            pw[k] = pw[k] ^ (64'd1 << $urandom_range(0, 63));
        end
        pgen = ($urandom_range(0, 9) == 0) ? $urandom : tracker.generation;
        pick = $urandom_range(0, 19);
        psess = (pick < 2) ? $urandom : (pick == 2) ? 32'd0 : (sess == 32'd0) ? $urandom : sess;
        pick = $urandom_range(0, 19);
        nwords = (pick == 0) ? 1 : (pick == 1) ? TOKEN_WORDS + 1 : TOKEN_WORDS;
        for (k = 0; k < nwords; k++) begin
            tick();
            send_command(CMD_PROOF, clock_ms, psess, pgen,
                         (k < TOKEN_WORDS) ? pw[k] : rand64(), k == nwords - 1);
        end
        // Follow-ups after the proof
        if ($urandom_range(0, 9) < 3) begin
            tick();
            send_command(CMD_READ, clock_ms, $urandom, $urandom, rand64(), 1'b0);
        end
        if ($urandom_range(0, 9) < 2) begin
            for (k = 0; k < TOKEN_WORDS; k++) begin
                tick();
                send_command(CMD_PROOF, clock_ms, psess, pgen, pw[k], k == TOKEN_WORDS - 1);
            end
        end
        if ($urandom_range(0, 9) < 3) begin
            tick();
            send_command(CMD_CANCEL, clock_ms, $urandom, $urandom, rand64(),
                         1'($urandom_range(0, 1)));
        end
        maybe_noise();
    endtask

    // Wait until every owed reply has come back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write both durations while idle, then run random attempts under them
    task automatic run_setting(input logic [31:0] life, input logic [31:0] win,
                               input int unsigned step, input int unsigned items);
        int unsigned target;
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOKEN_LIFETIME;
        cfg_data <= life;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data <= win;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(CFG_TOKEN_LIFETIME, life);
        tracker.set_register(CFG_WINDOW_LENGTH, win);
        settings_used++;
        step_ms = step;
        target = sent_total + items;
        while (sent_total < target)
            pairing_attempt();
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: spare codes and commands issued in the idle phase
        send_command(CMD_SPARE_A, '0, '0, '0, '0, 1'b0);
        send_command(CMD_SPARE_B, '1, '1, '1, '1, 1'b1);
        send_command(CMD_READ, '0, 32'd1, '0, '0, 1'b1);
        send_command(CMD_PROOF, '0, '0, '0, '0, 1'b1);
        send_command(CMD_OPEN, '0, '0, '0, '0, 1'b0);
        send_command(CMD_BIND, '0, '0, '0, '0, 1'b0);
        send_command(CMD_BIND, '0, 32'd7, '0, '0, 1'b0);
        // Prepare just before the clock wraps
        send_command(CMD_LOAD, 32'hffff_fff0, '0, '0, '1, 1'b0);
        send_command(CMD_LOAD, 32'hffff_fff0, '0, '0, '0, 1'b1);
        // Loads that are too short and too long
        send_command(CMD_LOAD, 32'hffff_fff8, '0, '0, 64'h0123_4567_89ab_cdef, 1'b1);
        send_command(CMD_LOAD, 32'hffff_fff8, '0, '0, '1, 1'b0);
        send_command(CMD_LOAD, 32'hffff_fff8, '0, '0, '1, 1'b0);
        send_command(CMD_LOAD, 32'hffff_fff8, '0, '0, '1, 1'b1);
        // Open after the wrap, bind, conflicting bind, read both words
        send_command(CMD_OPEN, 32'h0000_0010, '0, '0, '0, 1'b0);
        send_command(CMD_BIND, 32'h0000_0011, '1, '0, '0, 1'b0);
        send_command(CMD_BIND, 32'h0000_0012, 32'd1, '0, '0, 1'b0);
        send_command(CMD_READ, 32'h0000_0013, '0, '0, '0, 1'b0);
        // Wrong generation, then the good proof, short proof, consumed proof
        send_command(CMD_PROOF, 32'h0000_0014, '1, 32'd2, '1, 1'b0);
        send_command(CMD_PROOF, 32'h0000_0014, '1, 32'd2, '0, 1'b1);
        send_command(CMD_PROOF, 32'h0000_0015, '1, 32'd1, '1, 1'b0);
        send_command(CMD_PROOF, 32'h0000_0015, '1, 32'd1, '0, 1'b1);
        send_command(CMD_PROOF, 32'h0000_0016, '1, 32'd1, '1, 1'b1);
        send_command(CMD_PROOF, 32'h0000_0017, '1, 32'd1, '1, 1'b0);
        send_command(CMD_PROOF, 32'h0000_0017, '1, 32'd1, '0, 1'b1);
        send_command(CMD_CANCEL, 32'h0000_0018, '0, '0, '0, 1'b0);

        // Random attempts under a range of durations
        clock_ms = $urandom;
        run_setting(32'd0, 32'd0, 3000, 120);
        run_setting(32'd1, 32'd1, 2, 120);
        quiet = 1'b1;
        run_setting(32'hffff_ffff, 32'h8000_0000, 1 << 20, 120);
        quiet = 1'b0;
        run_setting(32'h7fff_ffff, 32'h7fff_fffe, 1 << 24, 120);
        run_setting($urandom_range(1, 200), $urandom_range(1, 100), 30, 120);
        run_setting($urandom, $urandom, 5000, 120);
        drain();

        $display("covered %0d commands: load %0d open %0d bind %0d proof %0d read %0d",
                 sent_total, sent_by_cmd[CMD_LOAD], sent_by_cmd[CMD_OPEN],
                 sent_by_cmd[CMD_BIND], sent_by_cmd[CMD_PROOF], sent_by_cmd[CMD_READ]);
        $display("cancel %0d spare %0d, %0d duration settings, %0d result beats, %0d mismatches",
                 sent_by_cmd[CMD_CANCEL],
                 sent_by_cmd[CMD_SPARE_A] + sent_by_cmd[CMD_SPARE_B],
                 settings_used, tracker.checked, tracker.failures);
        if (tracker.failures == 0 && tracker.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ one_time_token_pairing_fsm.f @@
rtl/otp_pkg.sv
rtl/otp_front.sv
rtl/otp_queue.sv
rtl/otp_back.sv
rtl/one_time_token_pairing_fsm.sv
tb/sv/one_time_token_pairing_fsm_test.sv
